### rtl/lbe_pkg.sv
// Package for the LED blink/breath effect engine: payload structs, codes,
// controller-to-datapath command and datapath-to-controller status structs. No dependencies.
package lbe_pkg;

  localparam logic [7:0] FullLevel = 8'd255;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_SET     = 3'd1,
    CMD_TOGGLE  = 3'd2,
    CMD_LEVEL   = 3'd3,
    CMD_COLOR   = 3'd4,
    CMD_BLINK   = 3'd5,
    CMD_BREATH  = 3'd6,
    CMD_UNUSED  = 3'd7
  } cmd_code_t;

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_BLINK  = 2'd1;
  localparam logic [1:0] MODE_BREATH = 2'd2;

  localparam logic [2:0] DRV_NONE    = 3'd0;
  localparam logic [2:0] DRV_ONOFF   = 3'd1;
  localparam logic [2:0] DRV_LEVEL   = 3'd2;
  localparam logic [2:0] DRV_COLOR   = 3'd3;
  localparam logic [2:0] DRV_MISSING = 3'd4;

  localparam logic [1:0] REG_STATE_OP = 2'd0;
  localparam logic [1:0] REG_LEVEL_OP = 2'd1;
  localparam logic [1:0] REG_RGB_OP   = 2'd2;

  typedef struct packed {
    logic [2:0]  cmd;
    logic        on_flag;
    logic [7:0]  level;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] period_time;
    logic [15:0] on_time;
    logic [7:0]  repeat_count;
    logic [15:0] elapsed_step;
  } lbe_in_t;

  typedef struct packed {
    logic [2:0] drive_kind;
    logic       drive_on;
    logic [7:0] drive_level;
    logic [7:0] drive_red;
    logic [7:0] drive_green;
    logic [7:0] drive_blue;
    logic       lit;
    logic [7:0] current_level;
    logic [1:0] effect_mode;
  } lbe_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture item, run immediate command
    logic div_start;  // start the serial divider for the current phase
    logic tick_fin;   // finish a tick from divider result
  } lbe_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_div;   // loaded item is a tick that needs division
    logic div_busy;
    logic ramp_div;   // second division (ramp) is required
  } lbe_stat_t;

endpackage

### rtl/led_blink_breath_effect_engine.sv
// LED blink/breath effect engine, top level.
// Commands finish without the divider; a blink tick takes one pass of the 24-bit
// serial divider and a breath tick one or two (an idle or zero-step tick takes none).
// Throughput: one item at a time; the next input is accepted only after the result
// is taken. Reset (rst, synchronous): LED off, no effect, on/off op only.
// Depends on lbe_pkg, lbe_ctrl, lbe_datapath, lbe_div.
module led_blink_breath_effect_engine
  import lbe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  lbe_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output lbe_out_t   out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic       cfg_data
);
  logic has_state_op, has_level_op, has_rgb_op;
  lbe_cmd_t  ctl;
  lbe_stat_t stat;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      has_state_op <= 1'b1; has_level_op <= 1'b0; has_rgb_op <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_STATE_OP: has_state_op <= cfg_data;
        REG_LEVEL_OP: has_level_op <= cfg_data;
        REG_RGB_OP:   has_rgb_op   <= cfg_data;
        default: ;
      endcase
    end
  end

  lbe_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .stat, .ctl
  );

  lbe_datapath u_dp (
    .clk, .rst, .item(in_data), .ctl, .has_state_op, .has_level_op, .has_rgb_op,
    .stat, .result(out_data)
  );
endmodule

### rtl/lbe_div.sv
// Shared restoring serial divider, one quotient bit per cycle.
// No package dependencies (no types used).
module lbe_div #(
  parameter int Width = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [Width-1:0] dividend,
  input  logic [Width-1:0] divisor,
  output logic             busy,
  output logic [Width-1:0] quotient,
  output logic [Width-1:0] remainder
);
  localparam int CntW = $clog2(Width + 1);

  logic [CntW-1:0] count;
  logic [Width-1:0] dsr;
  logic [Width:0]  trial;

  assign trial = {remainder, quotient[Width-1]} - {1'b0, dsr};

  // shift-subtract loop
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy      <= 1'b1;
      count     <= CntW'(Width);
      quotient  <= dividend;
      remainder <= '0;
      dsr       <= divisor;
    end else if (busy) begin
      if (trial[Width]) begin
        remainder <= {remainder[Width-2:0], quotient[Width-1]};
        quotient  <= {quotient[Width-2:0], 1'b0};
      end else begin
        remainder <= trial[Width-1:0];
        quotient  <= {quotient[Width-2:0], 1'b1};
      end
      count <= count - 1'b1;
      if (count == CntW'(1)) busy <= 1'b0;
    end
  end
endmodule

### rtl/lbe_datapath.sv
// Datapath: LED state, effect registers, drive fallback and result register.
// Depends on lbe_pkg and lbe_div.
module lbe_datapath
  import lbe_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  lbe_in_t   item,
  input  lbe_cmd_t  ctl,
  input  logic      has_state_op,
  input  logic      has_level_op,
  input  logic      has_rgb_op,
  output lbe_stat_t stat,
  output lbe_out_t  result
);
  localparam int DivW = 24;

  logic [1:0]  mode;
  logic        lit_flag;
  logic [7:0]  level_now, held_red, held_green, held_blue;
  logic [15:0] blink_span, blink_lit_span, blink_phase;
  logic [7:0]  blink_limit, blink_periods_done;
  logic        blink_lit;
  logic [15:0] breath_span, breath_phase;
  lbe_in_t     it;
  logic        ramp_pass;
  lbe_out_t    drv_q;

  logic             div_start;
  logic [DivW-1:0]  div_a, div_b, div_q, div_r;
  logic             div_busy;

  lbe_div #(.Width(DivW)) u_div (
    .clk, .rst, .start(div_start), .dividend(div_a), .divisor(div_b),
    .busy(div_busy), .quotient(div_q), .remainder(div_r)
  );

  // drive fallback helpers
  function automatic lbe_out_t drv_onoff(input logic on, input logic s, input logic l,
                                         input logic c);
    lbe_out_t o;
    o = '0;
    if (s) begin o.drive_kind = DRV_ONOFF; o.drive_on = on; end
    else if (l) begin o.drive_kind = DRV_LEVEL; o.drive_level = on ? FullLevel : 8'd0; end
    else if (c) begin
      o.drive_kind  = DRV_COLOR;
      o.drive_red   = on ? FullLevel : 8'd0;
      o.drive_green = on ? FullLevel : 8'd0;
      o.drive_blue  = on ? FullLevel : 8'd0;
    end else o.drive_kind = DRV_MISSING;
    return o;
  endfunction

  function automatic lbe_out_t drv_level(input logic [7:0] lv, input logic s,
                                         input logic l);
    lbe_out_t o;
    o = '0;
    if (l) begin o.drive_kind = DRV_LEVEL; o.drive_level = lv; end
    else if (s) begin o.drive_kind = DRV_ONOFF; o.drive_on = (lv != 8'd0); end
    else o.drive_kind = DRV_MISSING;
    return o;
  endfunction

  logic [7:0] max_rgb;
  always_comb begin
    max_rgb = item.red;
    if (item.green > max_rgb) max_rgb = item.green;
    if (item.blue > max_rgb) max_rgb = item.blue;
  end

  // tick arithmetic operands
  logic [16:0] blink_total, breath_total;
  logic [15:0] half, ramp_num_t;
  logic [8:0]  done_sum;
  logic [15:0] q16;
  logic [7:0]  lv_calc;
  logic        on_calc;
  assign blink_total  = {1'b0, blink_phase} + {1'b0, it.elapsed_step};
  assign breath_total = {1'b0, breath_phase} + {1'b0, it.elapsed_step};
  assign half         = breath_span >> 1;
  assign ramp_num_t   = (div_r[15:0] < half) ? div_r[15:0] : breath_span - div_r[15:0];
  assign q16          = div_q[15:0];
  assign lv_calc      = (div_q > DivW'(255)) ? FullLevel : div_q[7:0];
  assign done_sum     = {1'b0, blink_periods_done} + {1'b0, q16[7:0]};
  assign on_calc      = div_r[15:0] < blink_lit_span;

  wire tick_live = (it.cmd == CMD_TICK) && (it.elapsed_step != 16'd0) &&
                   ((mode == MODE_BLINK && blink_span != 16'd0) ||
                    (mode == MODE_BREATH && breath_span != 16'd0));

  assign stat.need_div = tick_live;
  assign stat.div_busy = div_busy;
  assign stat.ramp_div = (mode == MODE_BREATH) && !ramp_pass && (half != 16'd0);

  // divider operand select: first pass modulo, second pass ramp scale
  always_comb begin
    div_start = ctl.div_start;
    if (ramp_pass) begin
      div_a = DivW'(ramp_num_t) * DivW'(255);
      div_b = DivW'(half);
    end else if (mode == MODE_BLINK) begin
      div_a = DivW'(blink_total);
      div_b = DivW'(blink_span);
    end else begin
      div_a = DivW'(breath_total);
      div_b = DivW'(breath_span);
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NONE; lit_flag <= 1'b0; level_now <= '0;
      held_red <= '0; held_green <= '0; held_blue <= '0;
      blink_span <= '0; blink_lit_span <= '0; blink_limit <= '0;
      blink_periods_done <= '0; blink_phase <= '0; blink_lit <= 1'b0;
      breath_span <= '0; breath_phase <= '0; ramp_pass <= 1'b0;
    end else if (ctl.load) begin
      it <= item;
      ramp_pass <= 1'b0;
      drv_q <= '0;
      unique case (cmd_code_t'(item.cmd))
        CMD_TICK: begin
          // zero stored period stops the effect
          if (item.elapsed_step != 16'd0 &&
              ((mode == MODE_BLINK && blink_span == 16'd0) ||
               (mode == MODE_BREATH && breath_span == 16'd0)))
            mode <= MODE_NONE;
        end
        CMD_SET, CMD_TOGGLE: begin
          logic on;
          on = (item.cmd == CMD_SET) ? item.on_flag : !lit_flag;
          mode <= MODE_NONE; lit_flag <= on;
          level_now <= on ? FullLevel : 8'd0;
          held_red <= on ? FullLevel : 8'd0;
          held_green <= on ? FullLevel : 8'd0;
          held_blue <= on ? FullLevel : 8'd0;
          drv_q <= drv_onoff(on, has_state_op, has_level_op, has_rgb_op);
        end
        CMD_LEVEL: begin
          mode <= MODE_NONE; level_now <= item.level;
          lit_flag <= item.level != 8'd0;
          drv_q <= drv_level(item.level, has_state_op, has_level_op);
        end
        CMD_COLOR: begin
          lbe_out_t o;
          o = '0;
          if (has_rgb_op) begin
            o.drive_kind = DRV_COLOR; o.drive_red = item.red;
            o.drive_green = item.green; o.drive_blue = item.blue;
          end else if (has_level_op) begin
            o.drive_kind = DRV_LEVEL; o.drive_level = max_rgb;
          end else if (has_state_op) begin
            o.drive_kind = DRV_ONOFF; o.drive_on = (max_rgb != 8'd0);
          end else o.drive_kind = DRV_MISSING;
          mode <= MODE_NONE;
          held_red <= item.red; held_green <= item.green; held_blue <= item.blue;
          level_now <= max_rgb; lit_flag <= max_rgb != 8'd0;
          drv_q <= o;
        end
        CMD_BLINK: begin
          if (item.period_time != 16'd0) begin
            logic [15:0] ls;
            ls = (item.on_time > item.period_time) ? item.period_time : item.on_time;
            mode <= MODE_BLINK; blink_span <= item.period_time;
            blink_lit_span <= ls; blink_limit <= item.repeat_count;
            blink_phase <= '0; blink_periods_done <= '0;
            blink_lit <= ls != 16'd0; lit_flag <= ls != 16'd0;
            level_now <= (ls != 16'd0) ? FullLevel : 8'd0;
            drv_q <= drv_onoff(ls != 16'd0, has_state_op, has_level_op, has_rgb_op);
          end
        end
        CMD_BREATH: begin
          if (item.period_time != 16'd0) begin
            mode <= MODE_BREATH; breath_span <= item.period_time;
            breath_phase <= '0; level_now <= '0; lit_flag <= 1'b0;
            drv_q <= drv_level(8'd0, has_state_op, has_level_op);
          end
        end
        CMD_UNUSED: ;
        default: ;
      endcase
    end else if (ctl.tick_fin) begin
      if (mode == MODE_BLINK) begin
        blink_phase <= div_r[15:0];
        if (blink_limit != 8'd0 && q16 != 16'd0 &&
            (q16[15:8] != 8'd0 || done_sum >= {1'b0, blink_limit})) begin
          blink_periods_done <= blink_limit;
          mode <= MODE_NONE; lit_flag <= 1'b0; level_now <= '0; blink_lit <= 1'b0;
          drv_q <= drv_onoff(1'b0, has_state_op, has_level_op, has_rgb_op);
        end else begin
          if (blink_limit != 8'd0 && q16 != 16'd0) blink_periods_done <= done_sum[7:0];
          if (on_calc != blink_lit) begin
            blink_lit <= on_calc; lit_flag <= on_calc;
            level_now <= on_calc ? FullLevel : 8'd0;
            drv_q <= drv_onoff(on_calc, has_state_op, has_level_op, has_rgb_op);
          end
        end
      end else if (!ramp_pass) begin
        // breath modulo pass done
        breath_phase <= div_r[15:0];
        if (half == 16'd0) begin
          if (level_now != FullLevel) begin
            level_now <= FullLevel; lit_flag <= 1'b1;
            drv_q <= drv_level(FullLevel, has_state_op, has_level_op);
          end
        end else ramp_pass <= 1'b1;
      end else begin
        ramp_pass <= 1'b0;
        if (lv_calc != level_now) begin
          level_now <= lv_calc; lit_flag <= lv_calc != 8'd0;
          drv_q <= drv_level(lv_calc, has_state_op, has_level_op);
        end
      end
    end
  end

  // status fields follow the state registers
  lbe_out_t status_view;
  always_comb begin
    status_view = drv_q;
    status_view.lit = lit_flag;
    status_view.current_level = level_now;
    status_view.effect_mode = mode;
  end

  assign result = status_view;
endmodule

### rtl/lbe_ctrl.sv
// Controller state machine: sequences load, divider passes and result transfer.
// Depends on lbe_pkg.
module lbe_ctrl
  import lbe_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  lbe_stat_t stat,
  output lbe_cmd_t  ctl
);
  typedef enum logic [2:0] {S_IDLE, S_DECIDE, S_DSTART, S_DWAIT, S_FIN, S_OUT} state_t;
  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    ctl = '0;
    ctl.load      = in_valid && in_ready;
    ctl.div_start = (state == S_DSTART);
    ctl.tick_fin  = (state == S_FIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE:   if (in_valid) state <= S_DECIDE;
        S_DECIDE: if (stat.need_div) state <= S_DSTART;
                  else begin state <= S_OUT; out_valid <= 1'b1; end
        S_DSTART: state <= S_DWAIT;
        S_DWAIT:  if (!stat.div_busy) state <= S_FIN;
        S_FIN:    if (stat.ramp_div) state <= S_DSTART;
                  else begin state <= S_OUT; out_valid <= 1'b1; end
        S_OUT:    if (out_ready) begin state <= S_IDLE; out_valid <= 1'b0; end
        default:  state <= S_IDLE;
      endcase
    end
  end

  // no new item is accepted while a result is offered
  a_out_one: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("out_valid while accepting");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    ctl.div_start |=> stat.div_busy) else $error("divider did not start");
  a_drop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule

### tb/sv/tb_led_blink_breath_effect_engine.sv
// Testbench for the LED blink/breath effect engine: directed and random
// commands, a behavioral predictor and a result checker. Depends on lbe_pkg and the top level.
`timescale 1ns / 100ps

module tb_led_blink_breath_effect_engine;
  import lbe_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  lbe_in_t    in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  lbe_out_t   out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic       cfg_data = 1'b0;

  led_blink_breath_effect_engine DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the driver capabilities and LED state
  logic        op_state, op_level, op_rgb;
  logic [1:0]  fx_mode;
  logic        led_on;
  logic [7:0]  led_level, col_r, col_g, col_b;
  logic [15:0] bl_span, bl_lit_span, bl_phase;
  logic [7:0]  bl_limit, bl_done;
  logic        bl_lit;
  logic [15:0] br_span, br_phase;
  lbe_out_t    drv;

  lbe_out_t pending_results[$];
  int       err_count = 0;
  int       sent_count = 0;
  longint   cycle_count = 0;
  logic     burst_hold = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    err_count++;
  endtask

  function automatic void drive_onoff(input logic on);
    if (op_state) begin
      drv.drive_kind = DRV_ONOFF; drv.drive_on = on;
    end else if (op_level) begin
      drv.drive_kind = DRV_LEVEL; drv.drive_level = on ? FullLevel : 8'd0;
    end else if (op_rgb) begin
      drv.drive_kind = DRV_COLOR;
      drv.drive_red = on ? FullLevel : 8'd0;
      drv.drive_green = drv.drive_red; drv.drive_blue = drv.drive_red;
    end else begin
      drv.drive_kind = DRV_MISSING;
    end
  endfunction

  function automatic void drive_lvl(input logic [7:0] lv);
    if (op_level) begin
      drv.drive_kind = DRV_LEVEL; drv.drive_level = lv;
    end else if (op_state) begin
      drv.drive_kind = DRV_ONOFF; drv.drive_on = (lv != 0);
    end else begin
      drv.drive_kind = DRV_MISSING;
    end
  endfunction

  function automatic logic [7:0] max_of3(input logic [7:0] a, b, c);
    logic [7:0] m;
    m = a;
    if (b > m) m = b;
    if (c > m) m = c;
    return m;
  endfunction

  function automatic void set_led(input logic on);
    fx_mode = MODE_NONE; led_on = on;
    led_level = on ? FullLevel : 8'd0;
    col_r = led_level; col_g = led_level; col_b = led_level;
    drive_onoff(on);
  endfunction

  function automatic void led_reset();
    op_state = 1'b1; op_level = 1'b0; op_rgb = 1'b0;
    fx_mode = MODE_NONE; led_on = 1'b0; led_level = '0;
    col_r = '0; col_g = '0; col_b = '0;
    bl_span = '0; bl_lit_span = '0; bl_phase = '0; bl_limit = '0; bl_done = '0;
    bl_lit = 1'b0; br_span = '0; br_phase = '0;
  endfunction

  // expected result of one command
  function automatic lbe_out_t predict_led(input lbe_in_t it);
    logic [31:0] total, cycles, half, lv;
    logic        on;
    drv = '0;
    case (cmd_code_t'(it.cmd))
      CMD_TICK: begin
        if (it.elapsed_step != 0 && fx_mode == MODE_BLINK) begin
          if (bl_span == 0) fx_mode = MODE_NONE;
          else begin
            total = bl_phase + it.elapsed_step;
            cycles = total / bl_span;
            bl_phase = 16'(total % bl_span);
            if (bl_limit != 0 && cycles > 0 && bl_done + cycles >= bl_limit) begin
              bl_done = bl_limit; fx_mode = MODE_NONE;
              led_on = 1'b0; led_level = '0; bl_lit = 1'b0;
              drive_onoff(1'b0);
            end else begin
              if (bl_limit != 0 && cycles > 0) bl_done = 8'(bl_done + cycles);
              on = bl_phase < bl_lit_span;
              if (on != bl_lit) begin
                bl_lit = on; led_on = on;
                led_level = on ? FullLevel : 8'd0;
                drive_onoff(on);
              end
            end
          end
        end else if (it.elapsed_step != 0 && fx_mode == MODE_BREATH) begin
          if (br_span == 0) fx_mode = MODE_NONE;
          else begin
            total = (br_phase + it.elapsed_step) % br_span;
            br_phase = 16'(total);
            half = br_span / 2;
            if (half == 0) lv = 255;
            else if (total < half) lv = 255 * total / half;
            else lv = 255 * (br_span - total) / half;
            if (lv > 255) lv = 255;
            if (lv[7:0] != led_level) begin
              led_level = lv[7:0]; led_on = (lv != 0);
              drive_lvl(lv[7:0]);
            end
          end
        end
      end
      CMD_SET:    set_led(it.on_flag);
      CMD_TOGGLE: set_led(!led_on);
      CMD_LEVEL: begin
        fx_mode = MODE_NONE; led_level = it.level; led_on = (it.level != 0);
        drive_lvl(it.level);
      end
      CMD_COLOR: begin
        fx_mode = MODE_NONE;
        col_r = it.red; col_g = it.green; col_b = it.blue;
        led_level = max_of3(it.red, it.green, it.blue);
        led_on = (led_level != 0);
        if (op_rgb) begin
          drv.drive_kind = DRV_COLOR;
          drv.drive_red = it.red; drv.drive_green = it.green; drv.drive_blue = it.blue;
        end else if (op_level) begin
          drv.drive_kind = DRV_LEVEL; drv.drive_level = led_level;
        end else if (op_state) begin
          drv.drive_kind = DRV_ONOFF; drv.drive_on = led_on;
        end else begin
          drv.drive_kind = DRV_MISSING;
        end
      end
      CMD_BLINK: if (it.period_time != 0) begin
        fx_mode = MODE_BLINK; bl_span = it.period_time;
        bl_lit_span = (it.on_time > it.period_time) ? it.period_time : it.on_time;
        bl_limit = it.repeat_count; bl_phase = '0; bl_done = '0;
        bl_lit = (bl_lit_span != 0); led_on = bl_lit;
        led_level = bl_lit ? FullLevel : 8'd0;
        drive_onoff(bl_lit);
      end
      CMD_BREATH: if (it.period_time != 0) begin
        fx_mode = MODE_BREATH; br_span = it.period_time; br_phase = '0;
        led_level = '0; led_on = 1'b0;
        drive_lvl(8'd0);
      end
      default: ;
    endcase
    drv.lit = led_on; drv.current_level = led_level; drv.effect_mode = fx_mode;
    return drv;
  endfunction

  // send one command with burst gaps; prediction at acceptance
  task automatic send_cmd(input lbe_in_t it);
    @(posedge clk);
    if (!burst_hold && $urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    burst_hold <= ($urandom_range(0, 3) != 0);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_led(it));
    sent_count++;
    in_valid <= 1'b0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic val);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_STATE_OP: op_state = val;
      REG_LEVEL_OP: op_level = val;
      default:      op_rgb = val;
    endcase
  endtask

  task automatic set_ops(input logic s, input logic l, input logic c);
    write_reg(REG_STATE_OP, s);
    write_reg(REG_LEVEL_OP, l);
    write_reg(REG_RGB_OP, c);
  endtask

  function automatic lbe_in_t rand_cmd();
    lbe_in_t it;
    it = lbe_in_t'($bits(lbe_in_t)'({$urandom, $urandom, $urandom}));
    if ($urandom_range(0, 3) != 0) it.period_time = 16'($urandom_range(1, 40));
    if ($urandom_range(0, 3) != 0) it.on_time = 16'($urandom_range(0, 45));
    if ($urandom_range(0, 3) != 0) it.repeat_count = 8'($urandom_range(0, 6));
    if ($urandom_range(0, 3) != 0) it.elapsed_step = 16'($urandom_range(0, 30));
    // ticks dominate so effects run for a while
    if ($urandom_range(0, 9) < 5) it.cmd = CMD_TICK;
    return it;
  endfunction

  function automatic lbe_in_t mk(input cmd_code_t c);
    lbe_in_t it;
    it = '0;
    it.cmd = c;
    return it;
  endfunction

  // directed: extremes, every command, the special cases
  task automatic test_directed();
    lbe_in_t it;
    it = mk(CMD_UNUSED); it.elapsed_step = '1; send_cmd(it);
    it = mk(CMD_TICK); it.elapsed_step = 16'd5; send_cmd(it);
    it = mk(CMD_SET); it.on_flag = 1'b1; send_cmd(it);
    send_cmd(mk(CMD_TOGGLE));
    it = mk(CMD_LEVEL); it.level = 8'hFF; send_cmd(it);
    it = mk(CMD_COLOR); it.red = 8'hFF; it.green = 8'h01; send_cmd(it);
    it = mk(CMD_BLINK); send_cmd(it);
    it = mk(CMD_BLINK); it.period_time = '1; it.on_time = '1; send_cmd(it);
    it = mk(CMD_TICK); it.elapsed_step = '1; send_cmd(it);
    it = mk(CMD_BLINK); it.period_time = 16'd10; it.on_time = 16'd4;
    it.repeat_count = 8'd2;
    send_cmd(it);
    it = mk(CMD_TICK); it.elapsed_step = 16'd5; send_cmd(it);
    send_cmd(it);
    send_cmd(it);
    it = mk(CMD_BLINK); it.period_time = 16'd3; it.repeat_count = 8'hFF; send_cmd(it);
    it = mk(CMD_TICK); it.elapsed_step = 16'd0; send_cmd(it);
    it = mk(CMD_BREATH); it.period_time = 16'd1; send_cmd(it);
    it = mk(CMD_TICK); it.elapsed_step = 16'd1; send_cmd(it);
    it = mk(CMD_BREATH); it.period_time = 16'd7; send_cmd(it);
    it = mk(CMD_TICK); it.elapsed_step = 16'd4; send_cmd(it);
    it.elapsed_step = 16'd2; send_cmd(it);
    it = mk(CMD_BREATH); it.period_time = '1; send_cmd(it);
    it = mk(CMD_TICK); it.elapsed_step = 16'hFFFE; send_cmd(it);
  endtask

  task automatic test_random(input int count);
    repeat (count) send_cmd(rand_cmd());
  endtask

  // each driver capability mix, extremes first
  task automatic test_fallbacks();
    set_ops(1'b0, 1'b0, 1'b0); test_directed(); test_random(150);
    set_ops(1'b1, 1'b1, 1'b1); test_directed(); test_random(150);
    for (int m = 0; m < 8; m++) begin
      set_ops(m[0], m[1], m[2]);
      test_random(150);
    end
  endtask

  // result checker with its own stall pattern
  always @(posedge clk) begin
    lbe_out_t want;
    if (!rst) begin
      out_ready <= ($urandom_range(0, 3) != 0) || cycle_count[8];
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = pending_results.pop_front();
          if (out_data.drive_kind != want.drive_kind)
            report_mismatch("drive_kind", out_data.drive_kind, want.drive_kind);
          if (out_data.drive_on != want.drive_on)
            report_mismatch("drive_on", out_data.drive_on, want.drive_on);
          if (out_data.drive_level != want.drive_level)
            report_mismatch("drive_level", out_data.drive_level, want.drive_level);
          if (out_data.drive_red != want.drive_red)
            report_mismatch("drive_red", out_data.drive_red, want.drive_red);
          if (out_data.drive_green != want.drive_green)
            report_mismatch("drive_green", out_data.drive_green, want.drive_green);
          if (out_data.drive_blue != want.drive_blue)
            report_mismatch("drive_blue", out_data.drive_blue, want.drive_blue);
          if (out_data.lit != want.lit)
            report_mismatch("lit", out_data.lit, want.lit);
          if (out_data.current_level != want.current_level)
            report_mismatch("current_level", out_data.current_level, want.current_level);
          if (out_data.effect_mode != want.effect_mode)
            report_mismatch("effect_mode", out_data.effect_mode, want.effect_mode);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    led_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(200);
    test_fallbacks();
    set_ops(1'b1, 1'b0, 1'b0);
    test_random(100);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
